FILE: sv/nnis_pkg.sv
// Shared widths, codes and types of the nearest-neighbour image scaler.
package nnis_pkg;

  // Default store and destination limits for the top-level parameters.
  localparam int unsigned SRC_MAX_SIDE_DEF  = 128;
  localparam int unsigned DEST_MAX_SIDE_DEF = 4096;

  // Field widths.
  localparam int unsigned SRC_SIZE_W  = 8;
  localparam int unsigned DST_SIZE_W  = 13;
  localparam int unsigned SRC_COORD_W = 7;
  localparam int unsigned DST_COORD_W = 12;
  localparam int unsigned PIXEL_W     = 32;
  localparam int unsigned STATUS_W    = 2;

  // Scaling datapath: product of a destination coordinate and a source size,
  // and a quotient that always stays below the source size.
  localparam int unsigned PROD_W = DST_COORD_W + SRC_SIZE_W;
  localparam int unsigned QUO_W  = SRC_SIZE_W;
  localparam int unsigned CNT_W  = $clog2(QUO_W + 1);

  // Stream packing.
  localparam int unsigned IN_SRC_COL_LSB  = 0;
  localparam int unsigned IN_SRC_ROW_LSB  = IN_SRC_COL_LSB + SRC_COORD_W;
  localparam int unsigned IN_PIXEL_LSB    = IN_SRC_ROW_LSB + SRC_COORD_W;
  localparam int unsigned IN_DST_COL_LSB  = IN_PIXEL_LSB + PIXEL_W;
  localparam int unsigned IN_DST_ROW_LSB  = IN_DST_COL_LSB + DST_COORD_W;
  localparam int unsigned IN_USED_W       = IN_DST_ROW_LSB + DST_COORD_W;
  localparam int unsigned IN_TDATA_W      = ((IN_USED_W + 7) / 8) * 8;
  localparam int unsigned IN_TUSER_W      = 1;
  localparam int unsigned OUT_TDATA_W     = PIXEL_W;
  localparam int unsigned OUT_TUSER_W     = STATUS_W;

  // Configuration port.
  localparam int unsigned CFG_ADDR_W = 8;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_SRC_WIDTH  = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_SRC_HEIGHT = CFG_ADDR_W'(1);
  localparam logic [CFG_ADDR_W-1:0] REG_DST_WIDTH  = CFG_ADDR_W'(2);
  localparam logic [CFG_ADDR_W-1:0] REG_DST_HEIGHT = CFG_ADDR_W'(3);

  // Request kinds.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_DELIVERED = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] ST_WRITTEN   = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] ST_REJECTED  = STATUS_W'(2);

  // Request into the shared scaling divider.
  typedef struct packed {
    logic                   start;
    logic [DST_COORD_W-1:0] coord;
    logic [SRC_SIZE_W-1:0]  src_size;
    logic [DST_SIZE_W-1:0]  dst_size;
  } div_req_t;

  // Answer from the shared scaling divider.
  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quot;
  } div_rsp_t;

endpackage

FILE: sv/nnis_div.sv
// Shared scaling unit: coord * src_size / dst_size by restoring division.
module nnis_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  nnis_pkg::div_req_t req_i,
  output nnis_pkg::div_rsp_t rsp_o
);

  logic [nnis_pkg::PROD_W-1:0]     prod;
  logic [nnis_pkg::DST_SIZE_W-1:0] rem_q;
  logic [nnis_pkg::QUO_W-1:0]      quo_q;
  logic [nnis_pkg::DST_SIZE_W-1:0] dsz_q;
  logic [nnis_pkg::CNT_W-1:0]      cnt_q;
  logic                            busy_q;
  logic                            done_q;
  logic [nnis_pkg::DST_SIZE_W:0]   trial;
  logic [nnis_pkg::DST_SIZE_W:0]   diff;
  logic                            fits;

  // The product feeds the divider straight away; its upper part is already
  // below the divisor because the coordinate is below the destination size.
  assign prod = nnis_pkg::PROD_W'(req_i.coord) * nnis_pkg::PROD_W'(req_i.src_size);

  // One quotient bit per cycle.
  assign trial = {rem_q, quo_q[nnis_pkg::QUO_W-1]};
  assign diff  = trial - {1'b0, dsz_q};
  assign fits  = trial >= {1'b0, dsz_q};

  // Sequencing of the iterations.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= nnis_pkg::CNT_W'(nnis_pkg::QUO_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - nnis_pkg::CNT_W'(1);
        if (cnt_q == nnis_pkg::CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift register.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= nnis_pkg::DST_SIZE_W'(prod[nnis_pkg::PROD_W-1:nnis_pkg::QUO_W]);
      quo_q <= prod[nnis_pkg::QUO_W-1:0];
      dsz_q <= req_i.dst_size;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= diff[nnis_pkg::DST_SIZE_W-1:0];
      end else begin
        rem_q <= trial[nnis_pkg::DST_SIZE_W-1:0];
      end
      quo_q <= {quo_q[nnis_pkg::QUO_W-2:0], fits};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

FILE: sv/nearest_neighbor_image_scaler_unit.sv
// Top level of the nearest-neighbour image scaler: pixel store and sequencer.
//
//  Channel  Direction  Signals                        Meaning
//  s_axis   in         tvalid/tready/tdata/tuser      write or fetch request
//  m_axis   out        tvalid/tready/tdata/tuser      pixel and status result
//  cfg      in         valid/ready/addr/data          size register writes
//
// A write or a rejected fetch goes from acceptance to S_DONE, then into the result register.
// A valid fetch makes two passes of 8 iterations through
// the shared restoring divider (row, then column), plus a pixel store read.
// One request is in flight at a time; s_axis_tready_o is high only when the
// sequencer is idle. A held result stalls the sequencer until it is taken.
// Reset clears the size registers and control state; the store is not cleared.
module nearest_neighbor_image_scaler_unit #(
  parameter int unsigned SRC_MAX_SIDE  = nnis_pkg::SRC_MAX_SIDE_DEF,
  parameter int unsigned DEST_MAX_SIDE = nnis_pkg::DEST_MAX_SIDE_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Requests.
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // tdata: src_col[6:0], src_row[13:7], pixel_in[45:14], dest_col[57:46],
  // dest_row[69:58], zero fill [71:70].
  input  logic [nnis_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  // tuser: op[0].
  input  logic [nnis_pkg::IN_TUSER_W-1:0]   s_axis_tuser_i,
  // Results.
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // tdata: pixel_out[31:0].
  output logic [nnis_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  // tuser: status[1:0].
  output logic [nnis_pkg::OUT_TUSER_W-1:0]  m_axis_tuser_o,
  // Configuration writes.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [nnis_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [nnis_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned DEPTH  = SRC_MAX_SIDE * SRC_MAX_SIDE;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV_Y = 5'b00010,
    S_DIV_X = 5'b00100,
    S_READ  = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [nnis_pkg::SRC_SIZE_W-1:0] src_w_q, src_h_q;
  logic [nnis_pkg::DST_SIZE_W-1:0] dst_w_q, dst_h_q;

  logic                             in_op;
  logic [nnis_pkg::SRC_COORD_W-1:0] in_src_col, in_src_row;
  logic [nnis_pkg::PIXEL_W-1:0]     in_pixel;
  logic [nnis_pkg::DST_COORD_W-1:0] in_dst_col, in_dst_row;

  logic in_acc;
  logic fetch_ok;
  logic wr_ok;
  logic wr_en;
  logic rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;

  logic [nnis_pkg::DST_COORD_W-1:0] dx_q;
  logic [nnis_pkg::QUO_W-1:0]       sy_q;
  logic [nnis_pkg::QUO_W-1:0]       sx;
  logic [nnis_pkg::STATUS_W-1:0]    res_st_q;
  logic                             res_fetch_q;
  logic [nnis_pkg::PIXEL_W-1:0]     rd_data_q;

  logic                             out_valid_q;
  logic [nnis_pkg::PIXEL_W-1:0]     out_pix_q;
  logic [nnis_pkg::STATUS_W-1:0]    out_st_q;
  logic                             out_load;

  nnis_pkg::div_req_t div_req;
  nnis_pkg::div_rsp_t div_rsp;

  logic [nnis_pkg::PIXEL_W-1:0] mem [DEPTH];

  // Clamp a scaled coordinate to the last row or column.
  function automatic logic [nnis_pkg::QUO_W-1:0] clamp_coord(
    input logic [nnis_pkg::QUO_W-1:0]      q,
    input logic [nnis_pkg::SRC_SIZE_W-1:0] s
  );
    logic [nnis_pkg::QUO_W-1:0] r;
    r = q;
    if (q >= s) begin
      r = s - nnis_pkg::QUO_W'(1);
    end
    return r;
  endfunction

  // Request field unpacking.
  assign in_op      = s_axis_tuser_i[0];
  assign in_src_col = s_axis_tdata_i[nnis_pkg::IN_SRC_COL_LSB +: nnis_pkg::SRC_COORD_W];
  assign in_src_row = s_axis_tdata_i[nnis_pkg::IN_SRC_ROW_LSB +: nnis_pkg::SRC_COORD_W];
  assign in_pixel   = s_axis_tdata_i[nnis_pkg::IN_PIXEL_LSB +: nnis_pkg::PIXEL_W];
  assign in_dst_col = s_axis_tdata_i[nnis_pkg::IN_DST_COL_LSB +: nnis_pkg::DST_COORD_W];
  assign in_dst_row = s_axis_tdata_i[nnis_pkg::IN_DST_ROW_LSB +: nnis_pkg::DST_COORD_W];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  // Size and range checks for a fetch.
  assign fetch_ok = (src_w_q != '0) && (src_h_q != '0) &&
                    (dst_w_q != '0) && (dst_h_q != '0) &&
                    (32'(src_w_q) <= SRC_MAX_SIDE) && (32'(src_h_q) <= SRC_MAX_SIDE) &&
                    (32'(dst_w_q) <= DEST_MAX_SIDE) && (32'(dst_h_q) <= DEST_MAX_SIDE) &&
                    ({1'b0, in_dst_col} < dst_w_q) && ({1'b0, in_dst_row} < dst_h_q);

  // Store write address; a write outside the store is refused.
  assign wr_ok   = (32'(in_src_col) < SRC_MAX_SIDE) && (32'(in_src_row) < SRC_MAX_SIDE);
  assign wr_en   = in_acc && (in_op == nnis_pkg::OP_WRITE) && wr_ok;
  assign wr_addr = ADDR_W'(32'(in_src_row) * SRC_MAX_SIDE + 32'(in_src_col));

  // Read address once the column quotient arrives.
  assign sx      = clamp_coord(div_rsp.quot, src_w_q);
  assign rd_en   = (state_q == S_DIV_X) && div_rsp.done;
  assign rd_addr = ADDR_W'(32'(sy_q) * SRC_MAX_SIDE + 32'(sx));

  // The divider first scales the row straight from the request, then the column.
  always_comb begin
    div_req.start    = (in_acc && (in_op == nnis_pkg::OP_FETCH) && fetch_ok) ||
                       ((state_q == S_DIV_Y) && div_rsp.done);
    div_req.coord    = dx_q;
    div_req.src_size = src_w_q;
    div_req.dst_size = dst_w_q;
    if (state_q == S_IDLE) begin
      div_req.coord    = in_dst_row;
      div_req.src_size = src_h_q;
      div_req.dst_size = dst_h_q;
    end
  end

  nnis_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_load = (state_q == S_DONE) && (!out_valid_q || m_axis_tready_i);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if ((in_op == nnis_pkg::OP_FETCH) && fetch_ok) begin
            state_d = S_DIV_Y;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_DIV_Y: begin
        if (div_rsp.done) begin
          state_d = S_DIV_X;
        end
      end
      S_DIV_X: begin
        if (div_rsp.done) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers and size registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      src_w_q     <= '0;
      src_h_q     <= '0;
      dst_w_q     <= '0;
      dst_h_q     <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        unique case (cfg_addr_i)
          nnis_pkg::REG_SRC_WIDTH:  src_w_q <= cfg_data_i[nnis_pkg::SRC_SIZE_W-1:0];
          nnis_pkg::REG_SRC_HEIGHT: src_h_q <= cfg_data_i[nnis_pkg::SRC_SIZE_W-1:0];
          nnis_pkg::REG_DST_WIDTH:  dst_w_q <= cfg_data_i[nnis_pkg::DST_SIZE_W-1:0];
          nnis_pkg::REG_DST_HEIGHT: dst_h_q <= cfg_data_i[nnis_pkg::DST_SIZE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Request and result payload.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dx_q        <= in_dst_col;
      res_fetch_q <= (in_op == nnis_pkg::OP_FETCH) && fetch_ok;
      if (in_op == nnis_pkg::OP_FETCH) begin
        res_st_q <= fetch_ok ? nnis_pkg::ST_DELIVERED : nnis_pkg::ST_REJECTED;
      end else begin
        res_st_q <= wr_ok ? nnis_pkg::ST_WRITTEN : nnis_pkg::ST_REJECTED;
      end
    end
    if ((state_q == S_DIV_Y) && div_rsp.done) begin
      sy_q <= clamp_coord(div_rsp.quot, src_h_q);
    end
    if (out_load) begin
      out_pix_q <= res_fetch_q ? rd_data_q : '0;
      out_st_q  <= res_st_q;
    end
  end

  // Pixel store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= in_pixel;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_pix_q;
  assign m_axis_tuser_o  = out_st_q;

endmodule
